/* rtl/wsfp_pkg.sv */
package wsfp_pkg;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CLOSE    = 3'd1,
        EV_BIN_DONE = 3'd2,
        EV_PING     = 3'd3,
        EV_PONG     = 3'd4,
        EV_ERROR    = 3'd5
    } event_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    localparam logic [31:0] MAX_MSG_LEN_RESET = 32'd1048576;

    typedef struct packed {
        event_t      ev;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [31:0] mlen;
    } result_t;

    typedef struct packed {
        logic halted;
        logic in_header;
    } status_t;

endpackage

/* rtl/wsfp_parser.sv */
module wsfp_parser
    import wsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  byte_in,
    input  logic [31:0] max_len,
    output result_t     res,
    output status_t     status
);

    logic        in_header_reg, in_header_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  hdr_b0_reg, hdr_b0_next;
    logic [7:0]  hdr_b1_reg, hdr_b1_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic        final_reg, final_next;
    logic        close_reg, close_next;
    logic        mask_en_reg, mask_en_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  rx_idx_reg, rx_idx_next;
    logic [3:0]  msg_op_reg, msg_op_next;
    logic [31:0] msg_cnt_reg, msg_cnt_next;
    logic        halted_reg, halted_next;

    logic [7:0]  b0_cur, b1_cur;
    logic [6:0]  len_code;
    logic [3:0]  ext_len, need, cnt_inc;
    logic        in_len_field, in_key_field, hdr_last;
    logic [63:0] len_with, frame_len;
    logic [31:0] key_with;
    logic [3:0]  opcode, op_eff;
    logic        len_too_big;
    logic [7:0]  key_byte;
    logic [31:0] msg_cnt_inc;
    logic        done_fire, done_close, done_final;
    logic [3:0]  done_op;
    logic [31:0] done_len;

    always_comb begin
        b0_cur   = (hdr_cnt_reg == 4'd0) ? byte_in : hdr_b0_reg;
        b1_cur   = (hdr_cnt_reg == 4'd1) ? byte_in : hdr_b1_reg;
        len_code = b1_cur[6:0];
        if (len_code == LEN_CODE_16) begin
            ext_len = 4'd2;
        end else if (len_code == LEN_CODE_64) begin
            ext_len = 4'd8;
        end else begin
            ext_len = 4'd0;
        end
        need         = 4'd2 + ext_len + (b1_cur[7] ? 4'd4 : 4'd0);
        cnt_inc      = hdr_cnt_reg + 4'd1;
        in_len_field = (hdr_cnt_reg >= 4'd2) && (hdr_cnt_reg < 4'd2 + ext_len);
        in_key_field = (hdr_cnt_reg >= 4'd2 + ext_len) && b1_cur[7];
        hdr_last     = (hdr_cnt_reg != 4'd0) && (cnt_inc >= need);
        len_with     = in_len_field ? {len_acc_reg[55:0], byte_in} : len_acc_reg;
        key_with     = in_key_field ? {mask_key_reg[23:0], byte_in} : mask_key_reg;
        frame_len    = (ext_len == 4'd0) ? {57'd0, len_code} : len_with;
        opcode       = b0_cur[3:0];
        op_eff       = (opcode != OP_CONT) ? opcode : msg_op_reg;
        len_too_big  = (frame_len[63:32] != 32'd0) || (frame_len[31:0] > max_len);
        key_byte     = mask_key_reg[8*(3 - {30'd0, rx_idx_reg}) +: 8];
        msg_cnt_inc  = msg_cnt_reg + 32'd1;
    end

    always_comb begin
        in_header_next = in_header_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_b0_next    = hdr_b0_reg;
        hdr_b1_next    = hdr_b1_reg;
        len_acc_next   = len_acc_reg;
        final_next     = final_reg;
        close_next     = close_reg;
        mask_en_next   = mask_en_reg;
        mask_key_next  = mask_key_reg;
        remain_next    = remain_reg;
        rx_idx_next    = rx_idx_reg;
        msg_op_next    = msg_op_reg;
        msg_cnt_next   = msg_cnt_reg;
        halted_next    = halted_reg;
        res            = '{ev: EV_NONE, pvalid: 1'b0, pbyte: 8'd0, mlen: 32'd0};
        done_fire      = 1'b0;
        done_close     = close_reg;
        done_final     = final_reg;
        done_op        = msg_op_reg;
        done_len       = msg_cnt_reg;

        if (step && !halted_reg) begin
            if (in_header_reg) begin
                hdr_cnt_next  = cnt_inc;
                mask_key_next = key_with;
                len_acc_next  = len_with;
                if (hdr_cnt_reg == 4'd0) begin
                    hdr_b0_next = byte_in;
                end
                if (hdr_cnt_reg == 4'd1) begin
                    hdr_b1_next  = byte_in;
                    len_acc_next = 64'd0;
                end
                if (hdr_last) begin
                    final_next     = b0_cur[7];
                    mask_en_next   = b1_cur[7];
                    remain_next    = frame_len;
                    rx_idx_next    = 2'd0;
                    hdr_cnt_next   = 4'd0;
                    in_header_next = 1'b0;
                    if (opcode == OP_CLOSE) begin
                        close_next = 1'b1;
                        res.ev     = EV_CLOSE;
                        if (frame_len == 64'd0) begin
                            in_header_next = 1'b1;
                        end
                    end else begin
                        close_next  = 1'b0;
                        msg_op_next = op_eff;
                        if ((op_eff == OP_BIN && len_too_big) ||
                            ((op_eff == OP_PING || op_eff == OP_PONG) &&
                             frame_len > CTRL_MAX_LEN)) begin
                            res.ev      = EV_ERROR;
                            halted_next = 1'b1;
                        end else if (frame_len == 64'd0) begin
                            done_fire  = 1'b1;
                            done_close = 1'b0;
                            done_final = b0_cur[7];
                            done_op    = op_eff;
                            done_len   = msg_cnt_reg;
                        end
                    end
                end
            end else begin
                if (!close_reg && msg_op_reg == OP_BIN && msg_cnt_reg >= max_len) begin
                    res.ev      = EV_ERROR;
                    halted_next = 1'b1;
                end else begin
                    if (!close_reg && msg_op_reg == OP_BIN) begin
                        res.pvalid   = 1'b1;
                        res.pbyte    = mask_en_reg ? (byte_in ^ key_byte) : byte_in;
                        msg_cnt_next = msg_cnt_inc;
                        done_len     = msg_cnt_inc;
                    end
                    rx_idx_next = rx_idx_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    if (remain_reg == 64'd1) begin
                        done_fire = 1'b1;
                    end
                end
            end

            if (done_fire) begin
                in_header_next = 1'b1;
                if (!done_close) begin
                    case (done_op)
                        OP_BIN: begin
                            if (done_final) begin
                                res.ev       = EV_BIN_DONE;
                                res.mlen     = done_len;
                                msg_cnt_next = 32'd0;
                            end
                        end
                        OP_PING: res.ev = EV_PING;
                        OP_PONG: res.ev = EV_PONG;
                        default: res.ev = EV_NONE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_header_reg <= 1'b1;
            hdr_cnt_reg   <= 4'd0;
            final_reg     <= 1'b0;
            close_reg     <= 1'b0;
            mask_en_reg   <= 1'b0;
            mask_key_reg  <= 32'd0;
            remain_reg    <= 64'd0;
            rx_idx_reg    <= 2'd0;
            msg_op_reg    <= OP_CONT;
            msg_cnt_reg   <= 32'd0;
            halted_reg    <= 1'b0;
        end else begin
            in_header_reg <= in_header_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            final_reg     <= final_next;
            close_reg     <= close_next;
            mask_en_reg   <= mask_en_next;
            mask_key_reg  <= mask_key_next;
            remain_reg    <= remain_next;
            rx_idx_reg    <= rx_idx_next;
            msg_op_reg    <= msg_op_next;
            msg_cnt_reg   <= msg_cnt_next;
            halted_reg    <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_b0_reg  <= hdr_b0_next;
        hdr_b1_reg  <= hdr_b1_next;
        len_acc_reg <= len_acc_next;
    end

    assign status = '{halted: halted_reg, in_header: in_header_reg};

endmodule

/* rtl/wsfp_out_buf.sv */
module wsfp_out_buf
    import wsfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = ent0_reg;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        cnt_next  = cnt_reg;
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                ent0_next = push_data;
            end else begin
                ent0_next = ent1_reg;
                ent1_next = push_data;
            end
        end else if (push) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd0) begin
                ent0_next = push_data;
            end else begin
                ent1_next = push_data;
            end
        end else if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            ent0_next = ent1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

/* rtl/websocket_frame_parser_core.sv */
// Receive-side WebSocket frame parser, one stream byte per transfer. Takes a byte
// every cycle while the output buffer has room; each byte gives exactly one result
// transfer, registered in a two-entry output buffer, so the input keeps flowing
// while one result waits. Binary payload is unmasked and passed on byte by byte
// with m_payload_valid; fragments are joined and checked against max_message_length
// (cfg_wdata, written with cfg_we while idle: a rule on the user that the block
// does not enforce). Close, ping, pong, binary-done and errors are reported on
// m_event_res; after an error the block reports nothing further until reset.
module websocket_frame_parser_core
    import wsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [31:0] m_message_length
);

    logic [31:0] max_len_reg;
    logic        step;
    result_t     step_res;
    result_t     out_res;
    status_t     status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_MSG_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign step = s_valid && s_ready;

    wsfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .byte_in (s_byte_in),
        .max_len (max_len_reg),
        .res     (step_res),
        .status  (status)
    );

    wsfp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (step),
        .push_data  (step_res),
        .push_ready (s_ready),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (out_res)
    );

    assign m_event_res      = out_res.ev;
    assign m_payload_valid  = out_res.pvalid;
    assign m_payload_byte   = out_res.pbyte;
    assign m_message_length = out_res.mlen;

    a_payload_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |->
            (out_res.ev == EV_NONE || out_res.ev == EV_BIN_DONE))
        else $error("payload byte with a non-binary event");

    a_len_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_res.ev != EV_BIN_DONE |-> m_message_length == 32'd0)
        else $error("message length outside binary done");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && step_res.ev == EV_ERROR |=> status.halted)
        else $error("error did not halt parser");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        status.halted |-> step_res.ev == EV_NONE && !step_res.pvalid)
        else $error("halted parser produced a result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output buffer");

endmodule
